// ===== rtl/sdtq_pkg.sv =====
// Package for the sorted deadline timer queue.
// Holds sizes, operation codes, sequencer states and the cell entry and command types.
// No dependencies.
`default_nettype none

package sdtq_pkg;

  localparam int NUM_TIMERS = 16;
  localparam int TIME_WIDTH = 32;
  localparam int ID_WIDTH   = $clog2(NUM_TIMERS);
  localparam int OP_WIDTH   = 2;

  localparam logic [TIME_WIDTH-1:0] TIME_MAX = '1;

  typedef enum logic [OP_WIDTH-1:0] {
    OP_UPDATE  = 2'd0,
    OP_START   = 2'd1,
    OP_RESTART = 2'd2,
    OP_CANCEL  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REMOVE,
    ST_INSERT,
    ST_REPORT,
    ST_EXPIRE
  } state_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_REMOVE,
    CELL_INSERT,
    CELL_POP
  } cell_mode_t;

  typedef struct packed {
    logic                  valid;
    logic [ID_WIDTH-1:0]   id;
    logic [TIME_WIDTH-1:0] dl;
  } entry_t;

  typedef struct packed {
    cell_mode_t          mode;
    logic [ID_WIDTH-1:0] tgt_id;
    entry_t              new_ent;
  } cell_cmd_t;

  localparam entry_t ENTRY_EMPTY = '{valid: 1'b0, id: '0, dl: '0};

endpackage

`default_nettype wire

// ===== rtl/sdtq_cell.sv =====
// One cell of the sorted timer chain: holds a single armed timer entry.
// Removes, inserts and pops by trading entries with its two neighbors.
// Depends on sdtq_pkg.
`default_nettype none

module sdtq_cell
  import sdtq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cell_cmd_t cmd,
  input  entry_t    left_ent,
  input  logic      left_keep,
  input  logic      left_hit,
  input  entry_t    right_ent,
  output entry_t    ent,
  output logic      keep,
  output logic      hit
);

  entry_t ent_r;
  entry_t ent_nxt;
  logic   match;

  assign match = ent_r.valid && (ent_r.id == cmd.tgt_id);
  assign hit   = left_hit || match;
  assign keep  = ent_r.valid && (ent_r.dl <= cmd.new_ent.dl);
  assign ent   = ent_r;

  always_comb begin
    unique case (cmd.mode)
      CELL_HOLD:   ent_nxt = ent_r;
      CELL_REMOVE: ent_nxt = hit ? right_ent : ent_r;
      CELL_INSERT: begin
        if (keep) begin
          ent_nxt = ent_r;
        end else if (left_keep) begin
          ent_nxt = cmd.new_ent;
        end else begin
          ent_nxt = left_ent;
        end
      end
      CELL_POP:    ent_nxt = right_ent;
      default:     ent_nxt = ent_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r.valid <= 1'b0;
    end else begin
      ent_r.valid <= ent_nxt.valid;
    end
    ent_r.id <= ent_nxt.id;
    ent_r.dl <= ent_nxt.dl;
  end

endmodule

`default_nettype wire

// ===== rtl/sorted_deadline_timer_queue.sv =====
// Top level of the sorted deadline timer queue: sequencer, duration store and cell chain.
// Instantiates sdtq_cell; depends on sdtq_pkg.
//
//   channel  ports                                   handshake
//   in       in_operation in_timer_id in_duration_ms start / busy, taken when start && !busy
//            in_now_ms
//   out      out_fired out_fired_id out_last         out_valid strobe, one cycle per result
//            out_pending out_next_deadline out_time_to_next
//
// Start, restart: after the accept the sequencer steps through remove, insert and report,
// and the result is registered out of report. Cancel: remove and report only. Update: one
// cycle per expired timer (one pop of the head cell each), or a single report when nothing is due.
// The chain of NUM_TIMERS cells holds armed timers in deadline order; cell 0 is the head.
// Reset (rst_n low, synchronous) empties the chain and clears all stored durations.
// The receiver cannot stall: each result appears for exactly one cycle.
`default_nettype none

module sorted_deadline_timer_queue
  import sdtq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [OP_WIDTH-1:0]   in_operation,
  input  logic [ID_WIDTH-1:0]   in_timer_id,
  input  logic [TIME_WIDTH-1:0] in_duration_ms,
  input  logic [TIME_WIDTH-1:0] in_now_ms,
  output logic                  out_valid,
  output logic                  out_fired,
  output logic [ID_WIDTH-1:0]   out_fired_id,
  output logic                  out_last,
  output logic                  out_pending,
  output logic [TIME_WIDTH-1:0] out_next_deadline,
  output logic [TIME_WIDTH-1:0] out_time_to_next
);

  state_t                state_r, state_nxt;
  op_t                   op_r;
  logic [ID_WIDTH-1:0]   id_r;
  logic [TIME_WIDTH-1:0] now_r;
  logic [TIME_WIDTH-1:0] dl_r, dl_nxt;
  logic [TIME_WIDTH-1:0] stored_dur_r [NUM_TIMERS];

  logic                  out_valid_r, out_valid_nxt;
  logic                  out_fired_r, out_fired_nxt;
  logic [ID_WIDTH-1:0]   out_fired_id_r, out_fired_id_nxt;
  logic                  out_last_r, out_last_nxt;
  logic                  out_pending_r, out_pending_nxt;
  logic [TIME_WIDTH-1:0] out_nd_r, out_nd_nxt;
  logic [TIME_WIDTH-1:0] out_ttn_r, out_ttn_nxt;

  cell_cmd_t cmd;
  entry_t    ent  [NUM_TIMERS];
  logic      keep [NUM_TIMERS];
  logic      hit  [NUM_TIMERS];

  logic                  accept;
  logic                  due0;
  logic                  due1;
  entry_t                stat_ent;
  logic [TIME_WIDTH:0]   dl_sum;
  logic [TIME_WIDTH-1:0] stat_nd;
  logic [TIME_WIDTH-1:0] stat_ttn;

  assign accept = start && !busy;
  assign busy   = (state_r != ST_IDLE);

  // chain of cells, head at index 0
  genvar gc;
  for (gc = 0; gc < NUM_TIMERS; gc++) begin : g_cell
    entry_t left_ent;
    logic   left_keep;
    logic   left_hit;
    entry_t right_ent;

    if (gc == 0) begin : g_head
      assign left_ent  = ENTRY_EMPTY;
      assign left_keep = 1'b1;
      assign left_hit  = 1'b0;
    end else begin : g_body
      assign left_ent  = ent[gc-1];
      assign left_keep = keep[gc-1];
      assign left_hit  = hit[gc-1];
    end

    if (gc == NUM_TIMERS - 1) begin : g_tail
      assign right_ent = ENTRY_EMPTY;
    end else begin : g_inner
      assign right_ent = ent[gc+1];
    end

    sdtq_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cmd),
      .left_ent  (left_ent),
      .left_keep (left_keep),
      .left_hit  (left_hit),
      .right_ent (right_ent),
      .ent       (ent[gc]),
      .keep      (keep[gc]),
      .hit       (hit[gc])
    );
  end

  assign due0 = ent[0].valid && (ent[0].dl <= now_r);
  assign due1 = ent[1].valid && (ent[1].dl <= now_r);

  assign dl_sum = {1'b0, now_r} + {1'b0, stored_dur_r[id_r]};

  // head status after the current step
  assign stat_ent = ((state_r == ST_EXPIRE) && due0) ? ent[1] : ent[0];
  assign stat_nd  = stat_ent.valid ? stat_ent.dl : '0;
  assign stat_ttn = (stat_ent.valid && (now_r < stat_ent.dl)) ? (stat_ent.dl - now_r) : '0;

  always_comb begin
    state_nxt        = state_r;
    dl_nxt           = dl_r;
    cmd.mode         = CELL_HOLD;
    cmd.tgt_id       = id_r;
    cmd.new_ent      = '{valid: 1'b1, id: id_r, dl: dl_r};
    out_valid_nxt    = 1'b0;
    out_fired_nxt    = 1'b0;
    out_fired_id_nxt = '0;
    out_last_nxt     = 1'b1;
    out_pending_nxt  = stat_ent.valid;
    out_nd_nxt       = stat_nd;
    out_ttn_nxt      = stat_ttn;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = (op_t'(in_operation) == OP_UPDATE) ? ST_EXPIRE : ST_REMOVE;
        end
      end
      ST_REMOVE: begin
        cmd.mode  = CELL_REMOVE;
        dl_nxt    = dl_sum[TIME_WIDTH] ? TIME_MAX : dl_sum[TIME_WIDTH-1:0];
        state_nxt = (op_r == OP_CANCEL) ? ST_REPORT : ST_INSERT;
      end
      ST_INSERT: begin
        cmd.mode  = CELL_INSERT;
        state_nxt = ST_REPORT;
      end
      ST_REPORT: begin
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      ST_EXPIRE: begin
        out_valid_nxt = 1'b1;
        if (due0) begin
          cmd.mode         = CELL_POP;
          out_fired_nxt    = 1'b1;
          out_fired_id_nxt = ent[0].id;
          out_last_nxt     = !due1;
          if (!due1) begin
            state_nxt = ST_IDLE;
          end
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= op_t'(in_operation);
      id_r  <= in_timer_id;
      now_r <= in_now_ms;
    end
    dl_r           <= dl_nxt;
    out_fired_r    <= out_fired_nxt;
    out_fired_id_r <= out_fired_id_nxt;
    out_last_r     <= out_last_nxt;
    out_pending_r  <= out_pending_nxt;
    out_nd_r       <= out_nd_nxt;
    out_ttn_r      <= out_ttn_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_TIMERS; i++) begin
        stored_dur_r[i] <= '0;
      end
    end else if (accept && (op_t'(in_operation) == OP_START)) begin
      stored_dur_r[in_timer_id] <= in_duration_ms;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_fired         = out_fired_r;
  assign out_fired_id      = out_fired_id_r;
  assign out_last          = out_last_r;
  assign out_pending       = out_pending_r;
  assign out_next_deadline = out_nd_r;
  assign out_time_to_next  = out_ttn_r;

`ifndef SYNTHESIS
  a_result_follows_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without a request in progress");

  a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("request accepted but sequencer stayed idle");

  a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_pending) |-> (out_next_deadline == '0 && out_time_to_next == '0))
    else $error("empty queue reports a deadline");

  genvar ga;
  for (ga = 0; ga < NUM_TIMERS - 1; ga++) begin : g_chk
    a_chain_sorted: assert property (@(posedge clk) disable iff (!rst_n)
      ent[ga+1].valid |-> (ent[ga].valid && (ent[ga].dl <= ent[ga+1].dl)))
      else $error("timer chain out of order or has a gap");
  end
`endif

endmodule

`default_nettype wire

// ===== verif/sorted_deadline_timer_queue_tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for sorted_deadline_timer_queue: a directed request table, then random
// traffic with fill-and-expire bursts. Depends on sdtq_pkg and the top-level RTL only.

module sorted_deadline_timer_queue_tb;
  import sdtq_pkg::*;

  localparam int BURST_MAX   = 16;
  localparam int ITEM_TARGET = 400;
  localparam int IDLE_PCT    = 12;

  typedef struct packed {
    logic                  fired;
    logic [ID_WIDTH-1:0]   fired_id;
    logic                  last;
    logic                  pending;
    logic [TIME_WIDTH-1:0] next_deadline;
    logic [TIME_WIDTH-1:0] time_to_next;
  } status_t;

  typedef struct packed {
    op_t                   op;
    logic [ID_WIDTH-1:0]   id;
    logic [TIME_WIDTH-1:0] dur;
    logic [TIME_WIDTH-1:0] now;
    logic                  lit;
    status_t               lit_status;
  } request_row_t;

  localparam status_t NO_STATUS = '0;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [OP_WIDTH-1:0]   in_operation = '0;
  logic [ID_WIDTH-1:0]   in_timer_id = '0;
  logic [TIME_WIDTH-1:0] in_duration_ms = '0;
  logic [TIME_WIDTH-1:0] in_now_ms = '0;
  logic                  out_valid;
  logic                  out_fired;
  logic [ID_WIDTH-1:0]   out_fired_id;
  logic                  out_last;
  logic                  out_pending;
  logic [TIME_WIDTH-1:0] out_next_deadline;
  logic [TIME_WIDTH-1:0] out_time_to_next;

  logic [TIME_WIDTH-1:0] timer_deadline [NUM_TIMERS];
  logic [TIME_WIDTH-1:0] timer_duration [NUM_TIMERS];
  bit                    timer_armed    [NUM_TIMERS];
  logic [ID_WIDTH-1:0]   deadline_order [NUM_TIMERS];
  int                    armed_total;

  status_t awaited_status [$];
  status_t oldest_status;
  bit      allow_idle = 1'b1;
  int      error_count = 0;
  int      accepted_count = 0;
  int      expiry_count = 0;
  int      checked_count = 0;

  request_row_t directed_rows [20] = '{
    '{OP_UPDATE,  4'd0,  32'd0,          32'd0,          1'b1, '{1'b0, 4'd0, 1'b1, 1'b0, 32'd0, 32'd0}},
    '{OP_CANCEL,  4'd5,  32'd0,          32'd0,          1'b1, '{1'b0, 4'd0, 1'b1, 1'b0, 32'd0, 32'd0}},
    '{OP_RESTART, 4'd3,  32'hFFFF_FFFF,  32'd100,        1'b1, '{1'b0, 4'd0, 1'b1, 1'b1, 32'd100, 32'd0}},
    '{OP_START,   4'd15, 32'hFFFF_FFFF,  32'hFFFF_FFFF,  1'b1, '{1'b0, 4'd0, 1'b1, 1'b1, 32'd100, 32'd0}},
    '{OP_START,   4'd0,  32'd50,         32'd10,         1'b1, '{1'b0, 4'd0, 1'b1, 1'b1, 32'd60, 32'd50}},
    '{OP_START,   4'd1,  32'd50,         32'd10,         1'b0, NO_STATUS},
    '{OP_START,   4'd2,  32'd0,          32'd60,         1'b0, NO_STATUS},
    '{OP_UPDATE,  4'd9,  32'h5555_5555,  32'd59,         1'b0, NO_STATUS},
    '{OP_UPDATE,  4'd6,  32'hAAAA_AAAA,  32'd60,         1'b0, NO_STATUS},
    '{OP_RESTART, 4'd0,  32'd0,          32'd70,         1'b0, NO_STATUS},
    '{OP_START,   4'd1,  32'd5,          32'd70,         1'b0, NO_STATUS},
    '{OP_START,   4'd1,  32'd1,          32'd70,         1'b0, NO_STATUS},
    '{OP_CANCEL,  4'd3,  32'hFFFF_FFFF,  32'd72,         1'b0, NO_STATUS},
    '{OP_UPDATE,  4'd15, 32'd0,          32'hFFFF_FFFF,  1'b0, NO_STATUS},
    '{OP_START,   4'd7,  32'h8000_0000,  32'h8000_0000,  1'b0, NO_STATUS},
    '{OP_START,   4'd8,  32'h7FFF_FFFF,  32'h8000_0000,  1'b0, NO_STATUS},
    '{OP_UPDATE,  4'd0,  32'd0,          32'd0,          1'b0, NO_STATUS},
    '{OP_CANCEL,  4'd7,  32'd0,          32'h8000_0000,  1'b0, NO_STATUS},
    '{OP_UPDATE,  4'd0,  32'd0,          32'hFFFF_FFFF,  1'b0, NO_STATUS},
    '{OP_UPDATE,  4'd0,  32'd0,          32'hFFFF_FFFF,  1'b1, '{1'b0, 4'd0, 1'b1, 1'b0, 32'd0, 32'd0}}
  };

  sorted_deadline_timer_queue DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_operation      (in_operation),
    .in_timer_id       (in_timer_id),
    .in_duration_ms    (in_duration_ms),
    .in_now_ms         (in_now_ms),
    .out_valid         (out_valid),
    .out_fired         (out_fired),
    .out_fired_id      (out_fired_id),
    .out_last          (out_last),
    .out_pending       (out_pending),
    .out_next_deadline (out_next_deadline),
    .out_time_to_next  (out_time_to_next)
  );

  always #2 clk = ~clk;

  function automatic void unlink_timer(input int id);
    int pos;
    if (!timer_armed[id]) return;
    pos = armed_total;
    for (int i = 0; i < armed_total; i++) begin
      if (deadline_order[i] == id && pos == armed_total) pos = i;
    end
    for (int i = pos; i + 1 < armed_total; i++) deadline_order[i] = deadline_order[i + 1];
    if (pos < armed_total) armed_total--;
    timer_armed[id] = 1'b0;
  endfunction

  function automatic void arm_timer(input int id, input logic [TIME_WIDTH-1:0] now);
    logic [TIME_WIDTH:0] sum;
    int pos;
    sum = {1'b0, now} + {1'b0, timer_duration[id]};
    unlink_timer(id);
    timer_deadline[id] = sum[TIME_WIDTH] ? TIME_MAX : sum[TIME_WIDTH-1:0];
    pos = 0;
    while (pos < armed_total && timer_deadline[deadline_order[pos]] <= timer_deadline[id]) pos++;
    if (armed_total >= NUM_TIMERS) return;
    for (int i = armed_total; i > pos; i--) deadline_order[i] = deadline_order[i - 1];
    deadline_order[pos] = ID_WIDTH'(id);
    armed_total++;
    timer_armed[id] = 1'b1;
  endfunction

  function automatic status_t head_status(input logic fired, input logic [ID_WIDTH-1:0] id,
                                          input logic last, input logic [TIME_WIDTH-1:0] now);
    status_t s;
    s = '0;
    s.fired = fired;
    s.fired_id = fired ? id : '0;
    s.last = last;
    s.pending = armed_total > 0;
    if (armed_total > 0) begin
      s.next_deadline = timer_deadline[deadline_order[0]];
      s.time_to_next = (now >= s.next_deadline) ? '0 : s.next_deadline - now;
    end
    return s;
  endfunction

  function automatic void compute_timer_status(input op_t op, input logic [ID_WIDTH-1:0] id,
                                               input logic [TIME_WIDTH-1:0] dur,
                                               input logic [TIME_WIDTH-1:0] now);
    int n;
    logic [ID_WIDTH-1:0] due_id;
    logic more;
    n = 0;
    if (op == OP_UPDATE) begin
      while (n < BURST_MAX && armed_total > 0 && timer_deadline[deadline_order[0]] <= now) begin
        due_id = deadline_order[0];
        unlink_timer(due_id);
        n++;
        more = n < BURST_MAX && armed_total > 0 && timer_deadline[deadline_order[0]] <= now;
        awaited_status.push_back(head_status(1'b1, due_id, !more, now));
      end
      expiry_count += n;
      if (n > 0) return;
    end else if (op == OP_START) begin
      timer_duration[id] = dur;
      arm_timer(id, now);
    end else if (op == OP_RESTART) begin
      arm_timer(id, now);
    end else begin
      unlink_timer(id);
    end
    awaited_status.push_back(head_status(1'b0, '0, 1'b1, now));
  endfunction

  function automatic void check_field(input string name, input logic [TIME_WIDTH-1:0] want,
                                      input logic [TIME_WIDTH-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      error_count++;
    end
  endfunction

  task automatic send_request(input op_t op, input logic [ID_WIDTH-1:0] id,
                              input logic [TIME_WIDTH-1:0] dur,
                              input logic [TIME_WIDTH-1:0] now,
                              input logic lit, input status_t lit_status);
    @(negedge clk);
    while (allow_idle && $urandom_range(99) < IDLE_PCT) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    in_operation <= op;
    in_timer_id <= id;
    in_duration_ms <= dur;
    in_now_ms <= now;
    @(posedge clk);
    while (busy) @(posedge clk);
    compute_timer_status(op, id, dur, now);
    if (lit) awaited_status[awaited_status.size() - 1] = lit_status;
    accepted_count++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (awaited_status.size() == 0) begin
        $error("result with no request outstanding: fired %0b id %0d", out_fired, out_fired_id);
        error_count++;
      end else begin
        oldest_status = awaited_status.pop_front();
        checked_count++;
        check_field("fired", oldest_status.fired, out_fired);
        check_field("fired_id", oldest_status.fired_id, out_fired_id);
        check_field("last", oldest_status.last, out_last);
        check_field("pending", oldest_status.pending, out_pending);
        check_field("next_deadline", oldest_status.next_deadline, out_next_deadline);
        check_field("time_to_next", oldest_status.time_to_next, out_time_to_next);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    logic [TIME_WIDTH-1:0] clock_ms;
    logic [TIME_WIDTH-1:0] dur;
    op_t                   op;
    int                    random_sent;
    int                    pick;
    int                    base;
    bit                    drained;
    clock_ms = '0;
    random_sent = 0;
    drained = 1'b0;
    armed_total = 0;
    for (int i = 0; i < NUM_TIMERS; i++) begin
      timer_deadline[i] = '0;
      timer_duration[i] = '0;
      timer_armed[i] = 1'b0;
      deadline_order[i] = '0;
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].op, directed_rows[i].id, directed_rows[i].dur,
                   directed_rows[i].now, directed_rows[i].lit, directed_rows[i].lit_status);
    end

    while (random_sent < ITEM_TARGET) begin
      allow_idle = !(random_sent >= 150 && random_sent < 250);
      if (!drained && random_sent >= 100) begin
        // hold the sender until the queue drains
        @(negedge clk);
        start <= 1'b0;
        while (awaited_status.size() != 0) @(negedge clk);
        drained = 1'b1;
      end
      pick = $urandom_range(99);
      if (pick < 4) begin
        // fill every slot, then expire them in one update
        base = $urandom_range(NUM_TIMERS - 1);
        for (int t = 0; t < NUM_TIMERS; t++) begin
          send_request(OP_START, ID_WIDTH'((t + base) % NUM_TIMERS), $urandom_range(3),
                       clock_ms, 1'b0, NO_STATUS);
        end
        clock_ms += 4;
        send_request(OP_UPDATE, ID_WIDTH'($urandom_range(NUM_TIMERS - 1)), $urandom(),
                     clock_ms, 1'b0, NO_STATUS);
        random_sent += NUM_TIMERS + 1;
      end else begin
        if (pick < 6) clock_ms = $urandom();
        else if (pick < 7) clock_ms = TIME_MAX - $urandom_range(200);
        else clock_ms += $urandom_range(20);
        pick = $urandom_range(99);
        if (pick < 30) op = OP_UPDATE;
        else if (pick < 65) op = OP_START;
        else if (pick < 82) op = OP_RESTART;
        else op = OP_CANCEL;
        dur = ($urandom_range(99) < 85) ? $urandom_range(100) : $urandom();
        send_request(op, ID_WIDTH'($urandom_range(NUM_TIMERS - 1)), dur, clock_ms,
                     1'b0, NO_STATUS);
        random_sent++;
      end
    end

    @(negedge clk);
    start <= 1'b0;
    while (awaited_status.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    $display("Run covered %0d requests and %0d timer expiries; %0d reports checked.",
             accepted_count, expiry_count, checked_count);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
